// ----- src/cdn_pkg.sv -----
// shared types, constants and table functions for the calendar date normalizer
package cdn_pkg;

  localparam int YEAR_BITS = 10;
  localparam int YW        = YEAR_BITS + 2;   // signed working year width

  localparam int SEC_W  = 16;
  localparam int MIN_W  = 16;
  localparam int HOUR_W = 16;
  localparam int DAY_W  = 13;
  localparam int MON_W  = 4;

  localparam int IN_W       = SEC_W + MIN_W + HOUR_W + DAY_W + MON_W + YEAR_BITS;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  localparam int OSEC_W  = 6;
  localparam int OMIN_W  = 6;
  localparam int OHOUR_W = 5;
  localparam int ODAY_W  = 5;
  localparam int OUT_W   = OSEC_W + OMIN_W + OHOUR_W + ODAY_W + MON_W + YEAR_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // working widths
  localparam int WMIN_W = 17;   // minutes after seconds carry
  localparam int WHR_W  = 17;   // hours after minutes carry
  localparam int WDAY_W = 14;   // signed day after hours carry
  localparam int OPND_W = 17;   // constant divider operand
  localparam int RCP_W  = 19;   // reciprocal width
  localparam int RCP_SH = 23;   // reciprocal scale
  localparam int PROD_W = OPND_W + RCP_W;
  localparam int QUOT_W = PROD_W - RCP_SH;
  localparam int DVSR_W = 6;

  localparam logic signed [YW-1:0] YEAR_MAX_S = YW'((1 << YEAR_BITS) - 1);

  typedef enum logic [1:0] {
    DIV_SEC  = 2'd0,
    DIV_MIN  = 2'd1,
    DIV_HOUR = 2'd2,
    DIV_YEAR = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    logic     fix;
    logic     walk;
    logic     out_load;
    div_sel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic fits;
  } sts_t;

  // ceil(2^23 / divisor), exact floor for operands below 2^17
  function automatic logic [RCP_W-1:0] recip(input div_sel_t sel);
    logic [RCP_W-1:0] r;
    unique case (sel)
      DIV_SEC, DIV_MIN: r = RCP_W'(139811);
      DIV_HOUR:         r = RCP_W'(349526);
      DIV_YEAR:         r = RCP_W'(335545);
      default:          r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DVSR_W-1:0] divisor(input div_sel_t sel);
    logic [DVSR_W-1:0] d;
    unique case (sel)
      DIV_SEC, DIV_MIN: d = DVSR_W'(60);
      DIV_HOUR:         d = DVSR_W'(24);
      DIV_YEAR:         d = DVSR_W'(25);
      default:          d = '0;
    endcase
    return d;
  endfunction

  // common-year month lengths, index 0 is january
  function automatic logic [4:0] month_len(input logic [MON_W-1:0] mon);
    logic [4:0] d;
    unique case (mon)
      4'd1:                    d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- src/calendar_date_normalizer_core.sv -----
// calendar date normalizer: splits streams into fields and joins controller and datapath
//
// one request on the in_ side carries a broken-down date and time whose seconds, minutes,
// hours and day of month may be out of range; one result on the out_ side carries the same
// instant with every field in range and the year saturated, plus an overflow flag on tuser
// flow per request:
//   take the request, then do the carry work (sec/60, min/60, hour/24 and the full year
//   mod 25 for the leap rule) on one shared reciprocal-multiply divider, then step the
//   month one at a time until the day fits, then load the output register once it is free
// the month walk varies: no month is stepped for a date whose day already fits its month,
// and at most roughly 225 months forward or 135 back are stepped for the widest inputs
// in_tready is high only while the controller is idle, so one request is in flight at a time
// the finished result sits in an output register; a new request is taken while it waits,
// and the next result is held in the datapath until the receiver takes the old one
// reset (rst_n low, synchronous) returns the controller to idle and drops out_tvalid;
// there is no memory to clear
module calendar_date_normalizer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // seconds[15:0], minutes[31:16], hours[47:32], day[60:48], month[64:61], year[74:65]
  input  logic [cdn_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // seconds[5:0], minutes[11:6], hours[16:12], day[21:17], month[25:22], year[35:26]
  output logic [cdn_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // year_overflow[0]
  output logic                                out_tuser
);

  localparam int I_MIN  = cdn_pkg::SEC_W;
  localparam int I_HOUR = I_MIN + cdn_pkg::MIN_W;
  localparam int I_DAY  = I_HOUR + cdn_pkg::HOUR_W;
  localparam int I_MON  = I_DAY + cdn_pkg::DAY_W;
  localparam int I_YEAR = I_MON + cdn_pkg::MON_W;

  cdn_pkg::cmd_t cmd;
  cdn_pkg::sts_t sts;

  logic [cdn_pkg::OSEC_W-1:0]    o_sec;
  logic [cdn_pkg::OMIN_W-1:0]    o_min;
  logic [cdn_pkg::OHOUR_W-1:0]   o_hour;
  logic [cdn_pkg::ODAY_W-1:0]    o_day;
  logic [cdn_pkg::MON_W-1:0]     o_mon;
  logic [cdn_pkg::YEAR_BITS-1:0] o_year;

  // handshake and sequencing
  cdn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // field registers, divider, month walk and output register
  cdn_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .ld_sec  (in_tdata[I_MIN-1:0]),
    .ld_min  (in_tdata[I_HOUR-1:I_MIN]),
    .ld_hour (in_tdata[I_DAY-1:I_HOUR]),
    .ld_day  (in_tdata[I_MON-1:I_DAY]),
    .ld_mon  (in_tdata[I_YEAR-1:I_MON]),
    .ld_year (in_tdata[I_YEAR+cdn_pkg::YEAR_BITS-1:I_YEAR]),
    .o_sec   (o_sec),
    .o_min   (o_min),
    .o_hour  (o_hour),
    .o_day   (o_day),
    .o_mon   (o_mon),
    .o_year  (o_year),
    .o_ovf   (out_tuser)
  );

  // pack results lowest field first, zero padded to whole bytes
  assign out_tdata = cdn_pkg::OUT_TDATA_W'({o_year, o_mon, o_day, o_hour, o_min, o_sec});

endmodule

// ----- src/cdn_cdiv.sv -----
// divide by a small constant through a registered reciprocal product
module cdn_cdiv (
  input  logic                          clk,
  input  logic                          go,
  input  cdn_pkg::div_sel_t             sel,
  input  logic [cdn_pkg::OPND_W-1:0]    opnd,
  output logic [cdn_pkg::QUOT_W-1:0]    quot,
  output logic [cdn_pkg::DVSR_W-1:0]    rem
);

  logic [cdn_pkg::PROD_W-1:0] prod_r;
  logic [cdn_pkg::OPND_W-1:0] opnd_r;
  logic [cdn_pkg::DVSR_W-1:0] dvsr_r;
  logic [cdn_pkg::PROD_W-1:0] qd;
  logic [cdn_pkg::PROD_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= cdn_pkg::PROD_W'(opnd) * cdn_pkg::PROD_W'(cdn_pkg::recip(sel));
      opnd_r <= opnd;
      dvsr_r <= cdn_pkg::divisor(sel);
    end
  end

  assign quot = prod_r[cdn_pkg::PROD_W-1:cdn_pkg::RCP_SH];
  assign qd   = cdn_pkg::PROD_W'(quot) * cdn_pkg::PROD_W'(dvsr_r);
  assign diff = cdn_pkg::PROD_W'(opnd_r) - qd;
  assign rem  = diff[cdn_pkg::DVSR_W-1:0];

endmodule

// ----- src/cdn_dp.sv -----
// datapath: field registers, carry fixups, month walk and output register
module cdn_dp (
  input  logic                              clk,
  input  cdn_pkg::cmd_t                     cmd,
  output cdn_pkg::sts_t                     sts,
  input  logic [cdn_pkg::SEC_W-1:0]         ld_sec,
  input  logic [cdn_pkg::MIN_W-1:0]         ld_min,
  input  logic [cdn_pkg::HOUR_W-1:0]        ld_hour,
  input  logic signed [cdn_pkg::DAY_W-1:0]  ld_day,
  input  logic [cdn_pkg::MON_W-1:0]         ld_mon,
  input  logic [cdn_pkg::YEAR_BITS-1:0]     ld_year,
  output logic [cdn_pkg::OSEC_W-1:0]        o_sec,
  output logic [cdn_pkg::OMIN_W-1:0]        o_min,
  output logic [cdn_pkg::OHOUR_W-1:0]       o_hour,
  output logic [cdn_pkg::ODAY_W-1:0]        o_day,
  output logic [cdn_pkg::MON_W-1:0]         o_mon,
  output logic [cdn_pkg::YEAR_BITS-1:0]     o_year,
  output logic                              o_ovf
);

  logic [cdn_pkg::SEC_W-1:0]         sec_r;
  logic [cdn_pkg::WMIN_W-1:0]        min_r;
  logic [cdn_pkg::WHR_W-1:0]         hr_r;
  logic signed [cdn_pkg::WDAY_W-1:0] day_r;
  logic [cdn_pkg::MON_W-1:0]         mon_r;
  logic signed [cdn_pkg::YW-1:0]     yr_r;
  logic [4:0]                        ymod_r;   // full year mod 25

  logic [cdn_pkg::OPND_W-1:0] opnd;
  logic [cdn_pkg::QUOT_W-1:0] quot;
  logic [cdn_pkg::DVSR_W-1:0] rem;

  logic signed [18:0]         yfull_s;
  logic                       leap;
  logic [cdn_pkg::MON_W-1:0]  prev_mon;
  logic [4:0]                 md_cur;
  logic [4:0]                 md_prev;
  logic signed [cdn_pkg::WDAY_W-1:0] md_cur_s;
  logic signed [cdn_pkg::WDAY_W-1:0] md_prev_s;
  logic                       day_pos;
  logic                       fits;
  logic                       mon_wrap;

  assign yfull_s = 19'(yr_r) + 19'sd1900;
  // gregorian rule; with the year divisible by 4, mod 100 is mod 25 and mod 400 is mod 16
  assign leap = (yfull_s[1:0] == 2'd0) && ((ymod_r != 5'd0) || (yfull_s[3:0] == 4'd0));

  assign prev_mon  = (mon_r == 4'd0) ? 4'd11 : mon_r - 4'd1;
  assign md_cur    = cdn_pkg::month_len(mon_r) + {4'd0, (mon_r == 4'd1) && leap};
  // stepping back into february never crosses a year end
  assign md_prev   = cdn_pkg::month_len(prev_mon) + {4'd0, (prev_mon == 4'd1) && leap};
  assign md_cur_s  = cdn_pkg::WDAY_W'(md_cur);
  assign md_prev_s = cdn_pkg::WDAY_W'(md_prev);
  assign day_pos   = day_r > 0;
  assign fits      = day_pos && (day_r <= md_cur_s);
  assign mon_wrap  = (mon_r == 4'd11);
  assign sts.fits  = fits;

  always_comb begin
    case (cmd.div_sel)
      cdn_pkg::DIV_SEC:  opnd = cdn_pkg::OPND_W'(sec_r);
      cdn_pkg::DIV_MIN:  opnd = cdn_pkg::OPND_W'(min_r);
      cdn_pkg::DIV_HOUR: opnd = cdn_pkg::OPND_W'(hr_r);
      default:           opnd = yfull_s[cdn_pkg::OPND_W-1:0];
    endcase
  end

  cdn_cdiv u_cdiv (
    .clk  (clk),
    .go   (cmd.div_go),
    .sel  (cmd.div_sel),
    .opnd (opnd),
    .quot (quot),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_r <= ld_sec;
      min_r <= cdn_pkg::WMIN_W'(ld_min);
      hr_r  <= cdn_pkg::WHR_W'(ld_hour);
      day_r <= cdn_pkg::WDAY_W'(ld_day);
      // month codes past december roll into the next year
      if (ld_mon >= 4'd12) begin
        mon_r <= ld_mon - 4'd12;
        yr_r  <= cdn_pkg::YW'(ld_year) + cdn_pkg::YW'(1);
      end else begin
        mon_r <= ld_mon;
        yr_r  <= cdn_pkg::YW'(ld_year);
      end
    end else if (cmd.fix) begin
      case (cmd.div_sel)
        cdn_pkg::DIV_SEC: begin
          sec_r <= cdn_pkg::SEC_W'(rem);
          min_r <= min_r + cdn_pkg::WMIN_W'(quot);
        end
        cdn_pkg::DIV_MIN: begin
          min_r <= cdn_pkg::WMIN_W'(rem);
          hr_r  <= hr_r + cdn_pkg::WHR_W'(quot);
        end
        cdn_pkg::DIV_HOUR: begin
          hr_r  <= cdn_pkg::WHR_W'(rem);
          day_r <= day_r + cdn_pkg::WDAY_W'(quot);
        end
        default: begin
          ymod_r <= rem[4:0];
        end
      endcase
    end else if (cmd.walk && !fits) begin
      if (!day_pos) begin
        mon_r <= prev_mon;
        day_r <= day_r + md_prev_s;
        if (mon_r == 4'd0) begin
          yr_r   <= yr_r - cdn_pkg::YW'(1);
          ymod_r <= (ymod_r == 5'd0) ? 5'd24 : ymod_r - 5'd1;
        end
      end else begin
        day_r <= day_r - md_cur_s;
        mon_r <= mon_wrap ? 4'd0 : mon_r + 4'd1;
        if (mon_wrap) begin
          yr_r   <= yr_r + cdn_pkg::YW'(1);
          ymod_r <= (ymod_r == 5'd24) ? 5'd0 : ymod_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_sec  <= sec_r[cdn_pkg::OSEC_W-1:0];
      o_min  <= min_r[cdn_pkg::OMIN_W-1:0];
      o_hour <= hr_r[cdn_pkg::OHOUR_W-1:0];
      o_day  <= day_r[cdn_pkg::ODAY_W-1:0];
      o_mon  <= mon_r;
      if (yr_r > cdn_pkg::YEAR_MAX_S) begin
        o_year <= cdn_pkg::YEAR_MAX_S[cdn_pkg::YEAR_BITS-1:0];
        o_ovf  <= 1'b1;
      end else if (yr_r < 0) begin
        o_year <= '0;
        o_ovf  <= 1'b1;
      end else begin
        o_year <= yr_r[cdn_pkg::YEAR_BITS-1:0];
        o_ovf  <= 1'b0;
      end
    end
  end

endmodule

// ----- src/cdn_ctrl.sv -----
// controller: sequences load, carry divisions, month walk and result handoff
module cdn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  cdn_pkg::sts_t sts,
  output cdn_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_FIX_SEC,
    ST_DIV_MIN,
    ST_FIX_MIN,
    ST_DIV_HOUR,
    ST_FIX_HOUR,
    ST_DIV_YEAR,
    ST_FIX_YEAR,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = cdn_pkg::DIV_SEC;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = ST_DIV_SEC;
      end
      ST_DIV_SEC: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_FIX_SEC;
      end
      ST_FIX_SEC: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_DIV_MIN;
      end
      ST_DIV_MIN: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = cdn_pkg::DIV_MIN;
        state_nxt   = ST_FIX_MIN;
      end
      ST_FIX_MIN: begin
        cmd.fix     = 1'b1;
        cmd.div_sel = cdn_pkg::DIV_MIN;
        state_nxt   = ST_DIV_HOUR;
      end
      ST_DIV_HOUR: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = cdn_pkg::DIV_HOUR;
        state_nxt   = ST_FIX_HOUR;
      end
      ST_FIX_HOUR: begin
        cmd.fix     = 1'b1;
        cmd.div_sel = cdn_pkg::DIV_HOUR;
        state_nxt   = ST_DIV_YEAR;
      end
      ST_DIV_YEAR: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = cdn_pkg::DIV_YEAR;
        state_nxt   = ST_FIX_YEAR;
      end
      ST_FIX_YEAR: begin
        cmd.fix     = 1'b1;
        cmd.div_sel = cdn_pkg::DIV_YEAR;
        state_nxt   = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.fits) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
